// ===== hw/rtl/mpd_pkg.sv =====
// Shared constants and types for the magic packet detector.
package mpd_pkg;

    localparam int unsigned MAC_BYTES = 6;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned MAC_W     = MAC_BYTES * BYTE_W;

    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFF;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [MAC_W-1:0]  t_mac;

endpackage

// ===== hw/rtl/magic_packet_detector_top.sv =====
// Top level of the magic packet detector: request handshake, fill count, match latch.
//
//   channel  dir  handshake            payload
//   input    in   i_valid / o_ready    i_data_byte, i_last_byte
//   output   out  o_valid / i_ready    o_found, o_wake_mac
//
// One byte per cycle while o_ready is high; the pattern test on a byte's window runs
// in the cycle after it enters the cell row, and a last byte's result then moves from
// that test stage into the output register, where it is offered.
// A result passes through the cell row register and then the output register.
// Reset clears control only; window bytes stay stale but are guarded by the fill count.
// A stalled output holds only a pending last byte; other bytes keep flowing.
module magic_packet_detector_top #(
    parameter int unsigned SYNC_LEN = 6,
    parameter int unsigned REPEATS  = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  mpd_pkg::t_byte i_data_byte,
    input  logic           i_last_byte,
    output logic           o_valid,
    input  logic           i_ready,
    output logic           o_found,
    output mpd_pkg::t_mac  o_wake_mac
);
    import mpd_pkg::*;

    localparam int unsigned WIN_LEN = SYNC_LEN + MAC_BYTES * REPEATS;
    localparam int unsigned FILL_W  = $clog2(WIN_LEN + 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WIN_LEN);
    localparam logic [FILL_W-1:0] FILL_PRE = FILL_W'(WIN_LEN - 1);

    logic              w_accept;
    logic              w_s1_go;
    logic              w_magic;
    t_mac              w_mac;
    logic              w_hit;

    logic [FILL_W-1:0] r_fill, n_fill;
    logic              r_s1_valid, n_s1_valid;
    logic              r_s1_last, n_s1_last;
    logic              r_s1_full, n_s1_full;
    logic              r_match_seen, n_match_seen;
    t_mac              r_held_mac, n_held_mac;
    logic              r_out_valid, n_out_valid;
    logic              r_out_found, n_out_found;
    t_mac              r_out_mac, n_out_mac;

    assign w_s1_go  = r_s1_valid && (!r_s1_last || !r_out_valid || i_ready);
    assign o_ready  = !r_s1_valid || w_s1_go;
    assign w_accept = i_valid && o_ready;
    assign w_hit    = r_s1_full && w_magic && !r_match_seen;

    mpd_window #(
        .SYNC_LEN (SYNC_LEN),
        .REPEATS  (REPEATS)
    ) u_window (
        .i_clk   (i_clk),
        .i_shift (w_accept),
        .i_byte  (i_data_byte),
        .o_magic (w_magic),
        .o_mac   (w_mac)
    );

    always_comb begin
        n_fill       = r_fill;
        n_s1_valid   = r_s1_valid;
        n_s1_last    = r_s1_last;
        n_s1_full    = r_s1_full;
        n_match_seen = r_match_seen;
        n_held_mac   = r_held_mac;
        n_out_valid  = r_out_valid;
        n_out_found  = r_out_found;
        n_out_mac    = r_out_mac;

        // drain the output register
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        // resolve the byte in the test stage
        if (w_s1_go) begin
            n_s1_valid = 1'b0;
            if (r_s1_last) begin
                n_out_valid  = 1'b1;
                n_out_found  = r_match_seen || w_hit;
                n_out_mac    = r_match_seen ? r_held_mac : (w_hit ? w_mac : '0);
                n_match_seen = 1'b0;
                n_held_mac   = '0;
            end else if (w_hit) begin
                n_match_seen = 1'b1;
                n_held_mac   = w_mac;
            end
        end

        // advance a new byte into the window
        if (w_accept) begin
            n_s1_valid = 1'b1;
            n_s1_last  = i_last_byte;
            n_s1_full  = (r_fill >= FILL_PRE);
            if (i_last_byte) begin
                n_fill = '0;
            end else if (r_fill != FILL_MAX) begin
                n_fill = r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= '0;
            r_s1_valid   <= 1'b0;
            r_s1_last    <= 1'b0;
            r_s1_full    <= 1'b0;
            r_match_seen <= 1'b0;
            r_held_mac   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_fill       <= n_fill;
            r_s1_valid   <= n_s1_valid;
            r_s1_last    <= n_s1_last;
            r_s1_full    <= n_s1_full;
            r_match_seen <= n_match_seen;
            r_held_mac   <= n_held_mac;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_found <= n_out_found;
        r_out_mac   <= n_out_mac;
    end

    assign o_valid    = r_out_valid;
    assign o_found    = r_out_found;
    assign o_wake_mac = r_out_mac;

    a_out_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_s1_go && r_s1_last))
        else $error("result issued without a last byte");

    a_mac_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> (r_out_mac == '0))
        else $error("mac not zero on a miss");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_MAX)
        else $error("fill count beyond window length");

    a_match_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_go && r_s1_last) |=> (!r_match_seen && r_held_mac == '0))
        else $error("match state not cleared at packet end");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_last && r_out_valid && !i_ready) |-> !o_ready)
        else $error("input taken while last byte is stalled");

endmodule

// ===== hw/rtl/mpd_cell.sv =====
// One window cell: holds a byte, passes it on shift, compares it to a reference byte.
module mpd_cell (
    input  logic          i_clk,
    input  logic          i_shift,
    input  mpd_pkg::t_byte i_byte_in,
    input  mpd_pkg::t_byte i_ref,
    output mpd_pkg::t_byte o_byte,
    output logic          o_hit
);
    import mpd_pkg::*;

    t_byte r_byte;
    t_byte n_byte;

    always_comb begin
        n_byte = i_shift ? i_byte_in : r_byte;
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_byte = r_byte;
    assign o_hit  = (r_byte == i_ref);

endmodule

// ===== hw/rtl/mpd_window.sv =====
// Sliding byte window built from a row of cells, with the magic pattern test.
module mpd_window #(
    parameter int unsigned SYNC_LEN = 6,
    parameter int unsigned REPEATS  = 16
) (
    input  logic           i_clk,
    input  logic           i_shift,
    input  mpd_pkg::t_byte i_byte,
    output logic           o_magic,
    output mpd_pkg::t_mac  o_mac
);
    import mpd_pkg::*;

    localparam int unsigned WIN_LEN = SYNC_LEN + MAC_BYTES * REPEATS;
    localparam logic [WIN_LEN-1:0] TAIL_MASK =
        {{MAC_BYTES{1'b1}}, {(WIN_LEN - MAC_BYTES){1'b0}}};

    t_byte              w_byte [WIN_LEN];
    t_byte              w_ref  [WIN_LEN];
    logic [WIN_LEN-1:0] w_hit;

    for (genvar g = 0; g < WIN_LEN; g++) begin : g_cell
        t_byte w_in;

        if (g == WIN_LEN - 1) begin : g_head
            assign w_in = i_byte;
        end else begin : g_link
            assign w_in = w_byte[g+1];
        end

        if (g < SYNC_LEN) begin : g_sync
            assign w_ref[g] = SYNC_BYTE;
        end else if (g < WIN_LEN - MAC_BYTES) begin : g_rep
            assign w_ref[g] = w_byte[g+MAC_BYTES];
        end else begin : g_tail
            assign w_ref[g] = SYNC_BYTE;
        end

        mpd_cell u_cell (
            .i_clk     (i_clk),
            .i_shift   (i_shift),
            .i_byte_in (w_in),
            .i_ref     (w_ref[g]),
            .o_byte    (w_byte[g]),
            .o_hit     (w_hit[g])
        );
    end

    assign o_magic = &(w_hit | TAIL_MASK);

    always_comb begin
        o_mac = '0;
        for (int k = 0; k < MAC_BYTES; k++) begin
            o_mac[MAC_W-1-k*BYTE_W -: BYTE_W] = w_byte[SYNC_LEN+k];
        end
    end

endmodule
